>>> src/tws_pkg.sv
`timescale 1ns / 1ps

package tws_pkg;

    localparam int MAX_REQUESTS  = 64;
    localparam int POSITION_BITS = 20;
    localparam int ID_W          = 16;
    localparam int WRAP_W        = 8;
    localparam int IDX_W         = $clog2(MAX_REQUESTS);
    localparam int CNT_W         = $clog2(MAX_REQUESTS + 1);
    localparam int CUR_W         = POSITION_BITS + 2;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_LOAD     = 1'b0,
        OP_SCHEDULE = 1'b1
    } op_t;

    typedef struct packed {
        logic                     action;
        logic [ID_W-1:0]          request_id;
        logic [WRAP_W-1:0]        request_wrap;
        logic [POSITION_BITS-1:0] start_position;
        logic [POSITION_BITS-1:0] end_position;
        logic [WRAP_W-1:0]        head_wrap;
        logic [POSITION_BITS-1:0] head_position;
    } cmd_word_t;

    typedef struct packed {
        logic [ID_W-1:0] scheduled_id;
        logic            last_of_run;
    } id_word_t;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic [WRAP_W-1:0]        wrap;
        logic [POSITION_BITS-1:0] start_pos;
        logic [POSITION_BITS-1:0] end_pos;
    } entry_t;

    typedef struct packed {
        op_t                      op;
        logic                     forward;
        entry_t                   entry;
        logic [WRAP_W-1:0]        head_wrap;
        logic [POSITION_BITS-1:0] head_pos;
    } q_item_t;

endpackage

>>> src/tws_front.sv
`timescale 1ns / 1ps

module tws_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  tws_pkg::cmd_word_t  cmd_word,
    output logic                q_valid,
    output tws_pkg::q_item_t    q_item,
    input  logic                q_pop
);

    tws_pkg::q_item_t                 slot_reg [tws_pkg::QUEUE_DEPTH];
    logic [tws_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [tws_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [tws_pkg::QCNT_W-1:0]       fill_reg, fill_next;
    tws_pkg::q_item_t                 item;
    logic                             push;
    logic                             pop;

    // classify the word
    always_comb
    begin
        item.op           = cmd_word.action ? tws_pkg::OP_SCHEDULE : tws_pkg::OP_LOAD;
        item.forward      = ~cmd_word.request_wrap[0];
        item.entry.id        = cmd_word.request_id;
        item.entry.wrap      = cmd_word.request_wrap;
        item.entry.start_pos = cmd_word.start_position;
        item.entry.end_pos   = cmd_word.end_position;
        item.head_wrap    = cmd_word.head_wrap;
        item.head_pos     = cmd_word.head_position;
    end

    assign cmd_ready = (fill_reg != tws_pkg::QCNT_W'(tws_pkg::QUEUE_DEPTH));
    assign push      = cmd_valid && cmd_ready;
    assign q_valid   = (fill_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_item    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

>>> src/tws_back.sv
`timescale 1ns / 1ps

module tws_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  tws_pkg::q_item_t   q_item,
    output logic               q_pop,
    output logic               id_valid,
    input  logic               id_ready,
    output tws_pkg::id_word_t  id_word
);

    localparam int IW = tws_pkg::IDX_W;
    localparam int CW = tws_pkg::CNT_W;
    localparam int PW = tws_pkg::POSITION_BITS;
    localparam int WW = tws_pkg::WRAP_W;
    localparam int UW = tws_pkg::CUR_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_TAKE = 4'b0100,
        ST_TURN = 4'b1000
    } state_t;

    state_t                           state_reg, state_next;
    tws_pkg::entry_t                  mem [tws_pkg::MAX_REQUESTS];
    logic                             mem_we;
    logic [IW-1:0]                    mem_waddr;

    logic [CW-1:0]                    count_reg, count_next;
    logic [CW-1:0]                    fwd_cnt_reg, fwd_cnt_next;
    logic [CW-1:0]                    rev_cnt_reg, rev_cnt_next;
    logic [CW-1:0]                    emitted_reg, emitted_next;
    logic [tws_pkg::MAX_REQUESTS-1:0] served_reg, served_next;

    logic [PW-1:0]                    top_start_reg, top_start_next;
    logic [WW-1:0]                    top_wrap_reg, top_wrap_next;
    logic [PW-1:0]                    low_start_reg, low_start_next;
    logic [WW-1:0]                    low_wrap_reg, low_wrap_next;

    logic signed [UW-1:0]             cursor_reg, cursor_next;
    logic [WW-1:0]                    cur_wrap_reg, cur_wrap_next;
    logic                             rev_pass_reg, rev_pass_next;
    logic                             have_p_reg, have_p_next;
    logic [PW-1:0]                    p_start_reg, p_start_next;
    logic [IW-1:0]                    p_idx_reg, p_idx_next;

    logic [CW-1:0]                    scan_addr_reg, scan_addr_next;
    logic                             rd_valid_reg, rd_valid_next;
    logic [IW-1:0]                    rd_idx_reg, rd_idx_next;
    tws_pkg::entry_t                  rd_entry_reg;

    logic                             best_found_reg, best_found_next;
    logic [IW-1:0]                    best_idx_reg, best_idx_next;
    tws_pkg::entry_t                  best_entry_reg, best_entry_next;
    logic [WW-1:0]                    best_dist_reg, best_dist_next;

    logic                             out_valid_reg, out_valid_next;
    tws_pkg::id_word_t                out_word_reg, out_word_next;

    logic signed [UW-1:0]             rd_pos;
    logic [WW-1:0]                    rd_dist;
    logic                             beyond;
    logic                             after_p;
    logic                             qual;
    logic                             better;
    logic                             last;
    logic                             take_fire;
    logic                             out_free;

    assign id_valid = out_valid_reg;
    assign id_word  = out_word_reg;
    assign out_free = !out_valid_reg || id_ready;
    assign last     = ((emitted_reg + CW'(1)) == count_reg);

    always_comb
    begin
        rd_pos  = $signed({2'b00, rd_entry_reg.start_pos});
        rd_dist = (rd_entry_reg.wrap > cur_wrap_reg) ? rd_entry_reg.wrap - cur_wrap_reg
                                                     : cur_wrap_reg - rd_entry_reg.wrap;
        if (!rev_pass_reg)
        begin
            beyond  = rd_pos > cursor_reg;
            after_p = !have_p_reg || (rd_entry_reg.start_pos > p_start_reg)
                      || ((rd_entry_reg.start_pos == p_start_reg) && (rd_idx_reg > p_idx_reg));
            better  = !best_found_reg || (rd_entry_reg.start_pos < best_entry_reg.start_pos)
                      || ((rd_entry_reg.start_pos == best_entry_reg.start_pos)
                          && (rd_dist < best_dist_reg));
        end
        else
        begin
            beyond  = rd_pos < cursor_reg;
            after_p = !have_p_reg || (rd_entry_reg.start_pos < p_start_reg)
                      || ((rd_entry_reg.start_pos == p_start_reg) && (rd_idx_reg < p_idx_reg));
            better  = !best_found_reg || (rd_entry_reg.start_pos > best_entry_reg.start_pos)
                      || ((rd_entry_reg.start_pos == best_entry_reg.start_pos)
                          && (rd_dist <= best_dist_reg));
        end
        qual = rd_valid_reg && (rd_entry_reg.wrap[0] == rev_pass_reg)
               && !served_reg[rd_idx_reg] && beyond && after_p;
    end

    always_comb
    begin
        state_next      = state_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[IW-1:0];
        q_pop           = 1'b0;
        take_fire       = 1'b0;
        count_next      = count_reg;
        fwd_cnt_next    = fwd_cnt_reg;
        rev_cnt_next    = rev_cnt_reg;
        emitted_next    = emitted_reg;
        served_next     = served_reg;
        top_start_next  = top_start_reg;
        top_wrap_next   = top_wrap_reg;
        low_start_next  = low_start_reg;
        low_wrap_next   = low_wrap_reg;
        cursor_next     = cursor_reg;
        cur_wrap_next   = cur_wrap_reg;
        rev_pass_next   = rev_pass_reg;
        have_p_next     = have_p_reg;
        p_start_next    = p_start_reg;
        p_idx_next      = p_idx_reg;
        scan_addr_next  = scan_addr_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = rd_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_entry_next = best_entry_reg;
        best_dist_next  = best_dist_reg;
        out_valid_next  = out_valid_reg && !id_ready;
        out_word_next   = out_word_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.op == tws_pkg::OP_LOAD)
                    begin
                        if (count_reg < CW'(tws_pkg::MAX_REQUESTS))
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                            if (q_item.forward)
                            begin
                                fwd_cnt_next = fwd_cnt_reg + CW'(1);
                                if ((fwd_cnt_reg == '0)
                                    || (q_item.entry.start_pos < low_start_reg))
                                begin
                                    low_start_next = q_item.entry.start_pos;
                                    low_wrap_next  = q_item.entry.wrap;
                                end
                            end
                            else
                            begin
                                rev_cnt_next = rev_cnt_reg + CW'(1);
                                if ((rev_cnt_reg == '0)
                                    || (q_item.entry.start_pos >= top_start_reg))
                                begin
                                    top_start_next = q_item.entry.start_pos;
                                    top_wrap_next  = q_item.entry.wrap;
                                end
                            end
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        cursor_next     = $signed({2'b00, q_item.head_pos});
                        cur_wrap_next   = q_item.head_wrap;
                        rev_pass_next   = 1'b0;
                        have_p_next     = 1'b0;
                        emitted_next    = '0;
                        scan_addr_next  = '0;
                        best_found_next = 1'b0;
                        state_next      = (fwd_cnt_reg != '0) ? ST_SCAN : ST_TURN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_addr_reg < count_reg)
                begin
                    scan_addr_next = scan_addr_reg + CW'(1);
                    rd_valid_next  = 1'b1;
                    rd_idx_next    = scan_addr_reg[IW-1:0];
                end
                if (qual && better)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = rd_idx_reg;
                    best_entry_next = rd_entry_reg;
                    best_dist_next  = rd_dist;
                end
                if ((scan_addr_reg == count_reg) && !rd_valid_reg)
                begin
                    state_next = best_found_reg ? ST_TAKE : ST_TURN;
                end
            end
            ST_TAKE:
            begin
                if (out_free)
                begin
                    take_fire                  = 1'b1;
                    out_valid_next             = 1'b1;
                    out_word_next.scheduled_id = best_entry_reg.id;
                    out_word_next.last_of_run  = last;
                    served_next[best_idx_reg]  = 1'b1;
                    cursor_next                = $signed({2'b00, best_entry_reg.end_pos});
                    cur_wrap_next              = best_entry_reg.wrap;
                    have_p_next                = 1'b1;
                    p_start_next               = best_entry_reg.start_pos;
                    p_idx_next                 = best_idx_reg;
                    emitted_next               = emitted_reg + CW'(1);
                    scan_addr_next             = '0;
                    best_found_next            = 1'b0;
                    if (last)
                    begin
                        served_next  = '0;
                        count_next   = '0;
                        fwd_cnt_next = '0;
                        rev_cnt_next = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_TURN:
            begin
                have_p_next     = 1'b0;
                scan_addr_next  = '0;
                best_found_next = 1'b0;
                state_next      = ST_SCAN;
                if ((!rev_pass_reg && (rev_cnt_reg != '0))
                    || (rev_pass_reg && (fwd_cnt_reg == '0)))
                begin
                    rev_pass_next = 1'b1;
                    cursor_next   = $signed({2'b00, top_start_reg}) + UW'(1);
                    cur_wrap_next = top_wrap_reg;
                end
                else
                begin
                    rev_pass_next = 1'b0;
                    cursor_next   = $signed({2'b00, low_start_reg}) - UW'(1);
                    cur_wrap_next = low_wrap_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            fwd_cnt_reg    <= '0;
            rev_cnt_reg    <= '0;
            emitted_reg    <= '0;
            served_reg     <= '0;
            cursor_reg     <= '0;
            cur_wrap_reg   <= '0;
            rev_pass_reg   <= 1'b0;
            have_p_reg     <= 1'b0;
            scan_addr_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            fwd_cnt_reg    <= fwd_cnt_next;
            rev_cnt_reg    <= rev_cnt_next;
            emitted_reg    <= emitted_next;
            served_reg     <= served_next;
            cursor_reg     <= cursor_next;
            cur_wrap_reg   <= cur_wrap_next;
            rev_pass_reg   <= rev_pass_next;
            have_p_reg     <= have_p_next;
            scan_addr_reg  <= scan_addr_next;
            rd_valid_reg   <= rd_valid_next;
            best_found_reg <= best_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= q_item.entry;
        end
        rd_entry_reg   <= mem[scan_addr_reg[IW-1:0]];
        rd_idx_reg     <= rd_idx_next;
        top_start_reg  <= top_start_next;
        top_wrap_reg   <= top_wrap_next;
        low_start_reg  <= low_start_next;
        low_wrap_reg   <= low_wrap_next;
        p_start_reg    <= p_start_next;
        p_idx_reg      <= p_idx_next;
        best_idx_reg   <= best_idx_next;
        best_entry_reg <= best_entry_next;
        best_dist_reg  <= best_dist_next;
        out_word_reg   <= out_word_next;
    end

    a_emitted_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (emitted_reg < count_reg))
        else $error("emitted count reached batch size while busy");

    a_idle_nothing_served: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (served_reg == '0))
        else $error("served marks left set in idle");

    a_no_double_take: assert property (@(posedge clk) disable iff (!rst_n)
        take_fire |-> !served_reg[best_idx_reg])
        else $error("request taken twice");

    a_last_ends_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (take_fire && last) |=> ((state_reg == ST_IDLE) && (count_reg == '0)))
        else $error("batch not consumed after final word");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(tws_pkg::MAX_REQUESTS))
        else $error("load count beyond capacity");

endmodule

>>> src/tape_wrap_scan_scheduler.sv
`timescale 1ns / 1ps
// Load words: one accepted per cycle while the queue has room; each waits in the front queue
// until the idle back end pops it into the store. Schedule of n loaded requests: each
// output word costs one scan of the store (all n entries through the single read port)
// plus the ST_TAKE state to hand it off, which waits while the output word is held;
// a pass that ends empty costs one scan plus the ST_TURN state.
// Reset clears the queue, counts and served marks; stored entries are not cleared.

module tape_wrap_scan_scheduler
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  tws_pkg::cmd_word_t cmd_word,
    output logic               id_valid,
    input  logic               id_ready,
    output tws_pkg::id_word_t  id_word
);

    logic              q_valid;
    logic              q_pop;
    tws_pkg::q_item_t  q_item;

    tws_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    tws_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .id_valid (id_valid),
        .id_ready (id_ready),
        .id_word  (id_word)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT = 600000;

    typedef logic [tws_pkg::ID_W-1:0]          id_t;
    typedef logic [tws_pkg::WRAP_W-1:0]        wrap_t;
    typedef logic [tws_pkg::POSITION_BITS-1:0] pos_t;

    logic               clk;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_ready;
    tws_pkg::cmd_word_t cmd_word;
    logic               id_valid;
    logic               id_ready;
    tws_pkg::id_word_t  id_word;

    tape_wrap_scan_scheduler DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd_word (cmd_word),
        .id_valid (id_valid),
        .id_ready (id_ready),
        .id_word  (id_word)
    );

    id_t                batch_id   [tws_pkg::MAX_REQUESTS];
    wrap_t              batch_wrap [tws_pkg::MAX_REQUESTS];
    pos_t               batch_start[tws_pkg::MAX_REQUESTS];
    pos_t               batch_end  [tws_pkg::MAX_REQUESTS];
    int                 batch_count;
    tws_pkg::id_word_t  service_order[$];

    int  errors;
    int  words_sent;
    int  ids_checked;
    int  schedules_sent;
    int  cycles;
    int  hold_cycles;
    bit  quiet;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic int wrap_gap(wrap_t a, wrap_t b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    task automatic serve_batch(wrap_t hwrap, pos_t hpos);
        int       ord[tws_pkg::MAX_REQUESTS];
        bit       served[tws_pkg::MAX_REQUESTS];
        int       n;
        int       fwd;
        int       rev;
        int       k;
        int       best;
        int       j;
        int       emitted;
        int       before_round;
        longint   cur_pos;
        wrap_t    cur_wrap;
        tws_pkg::id_word_t out[$];
        tws_pkg::id_word_t w;
        n = batch_count;
        fwd = 0;
        rev = 0;
        emitted = 0;
        for (int i = 0; i < n; i++)
            if (!batch_wrap[i][0])
                fwd++;
        for (int i = 0; i < n; i++)
        begin
            served[i] = 1'b0;
            if (!batch_wrap[i][0])
            begin
                k = i - rev;
                while (k > 0 && batch_start[ord[k-1]] > batch_start[i])
                begin
                    ord[k] = ord[k-1];
                    k--;
                end
                ord[k] = i;
            end
            else
            begin
                k = fwd + rev;
                while (k > fwd && batch_start[ord[k-1]] > batch_start[i])
                begin
                    ord[k] = ord[k-1];
                    k--;
                end
                ord[k] = i;
                rev++;
            end
        end
        cur_wrap = hwrap;
        cur_pos = longint'(hpos);
        while (emitted < n)
        begin
            before_round = emitted;
            for (int i = 0; i < fwd; i++)
            begin
                if (!served[ord[i]] && longint'(batch_start[ord[i]]) > cur_pos)
                begin
                    best = i;
                    for (k = i + 1; k < fwd && batch_start[ord[k]] == batch_start[ord[i]]; k++)
                        if (!served[ord[k]] && wrap_gap(batch_wrap[ord[k]], cur_wrap)
                                < wrap_gap(batch_wrap[ord[best]], cur_wrap))
                            best = k;
                    i = best;
                    served[ord[best]] = 1'b1;
                    cur_wrap = batch_wrap[ord[best]];
                    cur_pos = longint'(batch_end[ord[best]]);
                    w.scheduled_id = batch_id[ord[best]];
                    w.last_of_run = 1'b0;
                    out.push_back(w);
                    emitted++;
                end
            end
            if (n > fwd)
            begin
                cur_pos = longint'(batch_start[ord[n-1]]) + 1;
                cur_wrap = batch_wrap[ord[n-1]];
                for (j = n - 1; j >= fwd; j--)
                begin
                    if (!served[ord[j]] && longint'(batch_start[ord[j]]) < cur_pos)
                    begin
                        best = j;
                        for (k = j - 1; k >= fwd && batch_start[ord[k]] == batch_start[ord[j]]; k--)
                            if (!served[ord[k]] && wrap_gap(batch_wrap[ord[k]], cur_wrap)
                                    < wrap_gap(batch_wrap[ord[best]], cur_wrap))
                                best = k;
                        j = best;
                        served[ord[best]] = 1'b1;
                        cur_wrap = batch_wrap[ord[best]];
                        cur_pos = longint'(batch_end[ord[best]]);
                        w.scheduled_id = batch_id[ord[best]];
                        w.last_of_run = 1'b0;
                        out.push_back(w);
                        emitted++;
                    end
                end
            end
            if (fwd > 0)
            begin
                cur_pos = longint'(batch_start[ord[0]]) - 1;
                cur_wrap = batch_wrap[ord[0]];
            end
            if (emitted == before_round && before_round > 0)
                break;
        end
        if (out.size() > 0)
            out[out.size()-1].last_of_run = 1'b1;
        foreach (out[i])
            service_order.push_back(out[i]);
        batch_count = 0;
    endtask

    task automatic account_word(tws_pkg::cmd_word_t w);
        if (w.action == tws_pkg::OP_LOAD)
        begin
            if (batch_count < tws_pkg::MAX_REQUESTS)
            begin
                batch_id[batch_count]    = w.request_id;
                batch_wrap[batch_count]  = w.request_wrap;
                batch_start[batch_count] = w.start_position;
                batch_end[batch_count]   = w.end_position;
                batch_count++;
            end
        end
        else
        begin
            schedules_sent++;
            serve_batch(w.head_wrap, w.head_position);
        end
    endtask

    task automatic send_word(tws_pkg::cmd_word_t w);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 6)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        account_word(w);
        words_sent++;
    endtask

    function automatic tws_pkg::cmd_word_t random_word();
        tws_pkg::cmd_word_t w;
        w.action         = tws_pkg::OP_LOAD;
        w.request_id     = id_t'($urandom);
        w.request_wrap   = wrap_t'($urandom);
        w.start_position = pos_t'($urandom);
        w.end_position   = pos_t'($urandom);
        w.head_wrap      = wrap_t'($urandom);
        w.head_position  = pos_t'($urandom);
        return w;
    endfunction

    task automatic load(id_t id, wrap_t wrap, pos_t s, pos_t e);
        tws_pkg::cmd_word_t w;
        w = random_word();
        w.action = tws_pkg::OP_LOAD;
        w.request_id = id;
        w.request_wrap = wrap;
        w.start_position = s;
        w.end_position = e;
        send_word(w);
    endtask

    task automatic schedule(wrap_t hw, pos_t hp);
        tws_pkg::cmd_word_t w;
        w = random_word();
        w.action = tws_pkg::OP_SCHEDULE;
        w.head_wrap = hw;
        w.head_position = hp;
        send_word(w);
    endtask

    task automatic drain();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (service_order.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            id_ready <= 1'b0;
        end
        else
            id_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 6);
    end

    always @(posedge clk)
    begin
        if (rst_n && id_valid && id_ready)
        begin
            if (service_order.size() == 0)
            begin
                $error("unexpected id word: scheduled_id %0h last_of_run %0b",
                       id_word.scheduled_id, id_word.last_of_run);
                errors++;
            end
            else
            begin
                if (id_word.scheduled_id !== service_order[0].scheduled_id)
                begin
                    $error("scheduled_id: expected %0h, actual %0h",
                           service_order[0].scheduled_id, id_word.scheduled_id);
                    errors++;
                end
                if (id_word.last_of_run !== service_order[0].last_of_run)
                begin
                    $error("last_of_run: expected %0b, actual %0b",
                           service_order[0].last_of_run, id_word.last_of_run);
                    errors++;
                end
                void'(service_order.pop_front());
                ids_checked++;
            end
        end
    end

    task automatic test_extremes();
        load(16'h0000, 8'h00, 20'h00000, 20'hFFFFF);
        load(16'hFFFF, 8'hFF, 20'hFFFFF, 20'h00000);
        load(16'h1234, 8'h02, 20'h00010, 20'h00020);
        load(16'h4321, 8'h01, 20'h00000, 20'h00005);
        load(16'h00AA, 8'hFE, 20'hFFFFF, 20'hFFFFF);
        schedule(8'h00, 20'h00000);
        schedule(8'hFF, 20'hFFFFF);
        drain();
    endtask

    task automatic test_equal_starts();
        load(16'h0101, 8'h08, 20'h00100, 20'h00150);
        load(16'h0102, 8'h04, 20'h00100, 20'h00110);
        load(16'h0103, 8'h04, 20'h00100, 20'h00120);
        load(16'h0104, 8'h05, 20'h00080, 20'h00070);
        load(16'h0105, 8'h09, 20'h00080, 20'h00060);
        load(16'h0106, 8'h03, 20'h00080, 20'h00050);
        schedule(8'h05, 20'h00050);
        drain();
    endtask

    task automatic test_one_direction();
        load(16'h0201, 8'h10, 20'h00300, 20'h00010);
        load(16'h0202, 8'h12, 20'h00200, 20'h00400);
        schedule(8'h10, 20'h00250);
        load(16'h0301, 8'h11, 20'h00300, 20'h00500);
        load(16'h0302, 8'h13, 20'h00200, 20'h00100);
        schedule(8'h00, 20'h00000);
        drain();
    endtask

    task automatic test_full_batch();
        quiet = 1'b1;
        for (int i = 0; i < tws_pkg::MAX_REQUESTS + 2; i++)
            load(id_t'($urandom), wrap_t'($urandom),
                 pos_t'($urandom_range(0, 40)), pos_t'($urandom_range(0, 40)));
        schedule(wrap_t'($urandom), pos_t'($urandom_range(0, 40)));
        drain();
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        for (int i = 0; i < 10; i++)
            load(id_t'($urandom), wrap_t'($urandom),
                 pos_t'($urandom_range(0, 31)), pos_t'($urandom_range(0, 31)));
        hold_cycles = 400;
        schedule(wrap_t'($urandom), pos_t'($urandom_range(0, 31)));
        for (int i = 0; i < 4; i++)
            load(id_t'($urandom), wrap_t'($urandom), pos_t'($urandom), pos_t'($urandom));
        schedule(wrap_t'($urandom), pos_t'($urandom));
        drain();
    endtask

    task automatic test_random(int budget);
        int size;
        int stop;
        stop = words_sent + budget;
        while (words_sent < stop)
        begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
            if ($urandom_range(0, 1))
                for (int i = 0; i < size; i++)
                    load(id_t'($urandom), wrap_t'($urandom),
                         pos_t'($urandom_range(0, 15)), pos_t'($urandom_range(0, 15)));
            else
                for (int i = 0; i < size; i++)
                    load(id_t'($urandom), wrap_t'($urandom), pos_t'($urandom), pos_t'($urandom));
            schedule(wrap_t'($urandom),
                     pos_t'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom));
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd_word = '0;
        id_ready = 1'b0;
        errors = 0;
        words_sent = 0;
        ids_checked = 0;
        schedules_sent = 0;
        cycles = 0;
        hold_cycles = 0;
        quiet = 1'b0;
        batch_count = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_extremes();
        test_equal_starts();
        test_one_direction();
        test_backpressure();
        test_random(20);
        quiet = 1'b1;
        test_random(15);
        quiet = 1'b0;
        test_full_batch();
        test_random(15);
        $display("covered %0d command words and %0d schedules, %0d ids checked",
                 words_sent, schedules_sent, ids_checked);
        $display("including full and overfull batches, empty schedules and a long output stall");
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
